// ----- sv/skf_pkg.sv -----
package skf_pkg;

    localparam int DATA_W    = 32;
    localparam int GAIN_W    = 17;
    localparam int FRAC_W    = 16;
    localparam int DIV_STEPS = GAIN_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W = 1;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 56;

    localparam logic [GAIN_W-1:0] ONE_Q16   = 17'h1_0000;
    localparam logic [DATA_W-1:0] P_RESET   = 32'h000A_0000;
    localparam logic [DATA_W-1:0] Q_RESET   = 32'h0001_0000;
    localparam logic [DATA_W-1:0] R_RESET   = 32'h0001_0000;
    localparam logic [CNT_W-1:0]  CNT_START = CNT_W'(DIV_STEPS - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROCESS_NOISE,
        REG_MEAS_NOISE
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRIOR,
        S_DIV,
        S_MULX,
        S_UPDX,
        S_MULP,
        S_UPDP,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic prior;
        logic div_step;
        logic mul_x;
        logic upd_x;
        logic mul_p;
        logic upd_p;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic div_last;
    } t_stat;

endpackage

// ----- sv/scalar_kalman_filter_core.sv -----
// Scalar Kalman filter with unit state transition and observation.
// Input channel (s_axis): each word carries one signed Q16.16 measurement.
// Output channel (m_axis): each word carries the updated estimate and the
// gain used for that step, one output word per input word.
// Configuration: a write with i_cfg_we high sets process noise (index 0) or
// measurement noise (index 1), both unsigned Q16.16; write only while idle.
// Each word passes these steps from acceptance to the output register: the prior
// variance, a restoring divider that forms the gain one bit per cycle,
// two multiply/update pairs on one shared multiplier, and the load of the
// result. The next word is taken only once the result is loaded and the block
// is idle again, so no new word is accepted while an update is in progress.
// The finished word waits in an output register; if the receiver stalls, the
// block finishes the next update and then holds until that register frees.
// Reset sets the estimate to 0, the variance to 10.0 and both noise values
// to 1.0, and empties the output register.
module scalar_kalman_filter_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [skf_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,  // [31:0] measurement
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [skf_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,  // [31:0] estimate, [48:32] gain
    input  logic                              i_cfg_we,
    input  logic [skf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [skf_pkg::DATA_W-1:0]        i_cfg_data
);
    import skf_pkg::*;

    t_cmd              cmd;
    t_stat             stat;
    logic [DATA_W-1:0] est;
    logic [GAIN_W-1:0] gain;

    skf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    skf_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_meas     (i_s_axis_tdata[DATA_W-1:0]),
        .o_est      (est),
        .o_gain     (gain)
    );

    assign o_m_axis_tdata = {{(OUT_TDATA_W-DATA_W-GAIN_W){1'b0}}, gain, est};

endmodule

// ----- sv/skf_ctrl.sv -----
module skf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  skf_pkg::t_stat i_stat,
    output skf_pkg::t_cmd  o_cmd
);
    import skf_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_PRIOR;
            S_PRIOR: n_state = S_DIV;
            S_DIV:   if (i_stat.div_last) n_state = S_MULX;
            S_MULX:  n_state = S_UPDX;
            S_UPDX:  n_state = S_MULP;
            S_MULP:  n_state = S_UPDP;
            S_UPDP:  n_state = S_OUT;
            S_OUT:   if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        cmd        = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                cmd.accept = i_in_valid;
            end
            S_PRIOR: cmd.prior    = 1'b1;
            S_DIV:   cmd.div_step = 1'b1;
            S_MULX:  cmd.mul_x    = 1'b1;
            S_UPDX:  cmd.upd_x    = 1'b1;
            S_MULP:  cmd.mul_p    = 1'b1;
            S_UPDP:  cmd.upd_p    = 1'b1;
            S_OUT:   cmd.load_out = !r_out_valid || i_out_ready;
            default: cmd = '0;
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_out_valid = r_out_valid;

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.prior, cmd.div_step, cmd.mul_x, cmd.upd_x, cmd.mul_p,
                  cmd.upd_p, cmd.load_out, cmd.accept}))
        else $error("more than one datapath command in a cycle");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept |=> r_state == S_PRIOR)
        else $error("accepted word did not start the update");

    a_load_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten while stalled");

endmodule

// ----- sv/skf_dp.sv -----
module skf_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  skf_pkg::t_cmd                  i_cmd,
    output skf_pkg::t_stat                 o_stat,
    input  logic                           i_cfg_we,
    input  logic [skf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [skf_pkg::DATA_W-1:0]     i_cfg_data,
    input  logic [skf_pkg::DATA_W-1:0]     i_meas,
    output logic [skf_pkg::DATA_W-1:0]     o_est,
    output logic [skf_pkg::GAIN_W-1:0]     o_gain
);
    import skf_pkg::*;

    logic [DATA_W-1:0]   r_q, r_r;
    logic [DATA_W-1:0]   r_x, r_p;
    logic [DATA_W-1:0]   r_z;
    logic [DATA_W-1:0]   r_prior;
    logic [DATA_W:0]     r_den;
    logic                r_den_zero;
    logic signed [DATA_W:0] r_diff;
    logic [DATA_W:0]     r_rem;
    logic [GAIN_W-1:0]   r_dvd;
    logic [GAIN_W-1:0]   r_quo;
    logic [CNT_W-1:0]    r_cnt;
    logic signed [DATA_W+GAIN_W+1:0] r_prod;
    logic [DATA_W-1:0]   r_out_est;
    logic [GAIN_W-1:0]   r_out_gain;

    logic [DATA_W:0]     p_sum;
    logic [DATA_W-1:0]   prior_w;
    logic [DATA_W+1:0]   trial;
    logic                ge;
    logic [DATA_W+1:0]   trial_sub;
    logic [GAIN_W-1:0]   k_w;
    logic signed [DATA_W:0]  mul_a;
    logic signed [GAIN_W:0]  mul_b;
    logic signed [DATA_W+2:0] x_inc;
    logic signed [DATA_W+3:0] x_sum;
    logic [DATA_W-1:0]   x_sat;

    always_comb begin
        p_sum   = {1'b0, r_p} + {1'b0, r_q};
        prior_w = p_sum[DATA_W] ? '1 : p_sum[DATA_W-1:0];
    end

    always_comb begin
        trial     = {r_rem, r_dvd[GAIN_W-1]};
        ge        = trial >= {1'b0, r_den};
        trial_sub = trial - {1'b0, r_den};
        k_w       = r_den_zero ? '0 : r_quo;
    end

    always_comb begin
        if (i_cmd.mul_p) begin
            mul_a = $signed({1'b0, r_prior});
            mul_b = $signed({1'b0, ONE_Q16 - k_w});
        end else begin
            mul_a = r_diff;
            mul_b = $signed({1'b0, k_w});
        end
    end

    always_comb begin
        x_inc = r_prod[DATA_W+GAIN_W+1:FRAC_W];
        x_sum = $signed({{4{r_x[DATA_W-1]}}, r_x}) + $signed({x_inc[DATA_W+2], x_inc});
        if (x_sum > $signed({4'b0000, 1'b0, {(DATA_W-1){1'b1}}})) begin
            x_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (x_sum < $signed({4'b1111, 1'b1, {(DATA_W-1){1'b0}}})) begin
            x_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            x_sat = x_sum[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= Q_RESET;
            r_r <= R_RESET;
            r_x <= '0;
            r_p <= P_RESET;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_PROCESS_NOISE: r_q <= i_cfg_data;
                    REG_MEAS_NOISE:    r_r <= i_cfg_data;
                    default:           r_q <= r_q;
                endcase
            end
            if (i_cmd.upd_x) r_x <= x_sat;
            if (i_cmd.upd_p) r_p <= r_prod[DATA_W+FRAC_W-1:FRAC_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_z <= i_meas;
        if (i_cmd.prior) begin
            r_prior    <= prior_w;
            r_den      <= {1'b0, prior_w} + {1'b0, r_r};
            r_den_zero <= (prior_w == '0) && (r_r == '0);
            r_diff     <= $signed({r_z[DATA_W-1], r_z}) - $signed({r_x[DATA_W-1], r_x});
            r_rem      <= {2'b00, prior_w[DATA_W-1:1]};
            r_dvd      <= {prior_w[0], {(GAIN_W-1){1'b0}}};
            r_quo      <= '0;
            r_cnt      <= CNT_START;
        end
        if (i_cmd.div_step) begin
            r_rem <= ge ? trial_sub[DATA_W:0] : trial[DATA_W:0];
            r_dvd <= {r_dvd[GAIN_W-2:0], 1'b0};
            r_quo <= {r_quo[GAIN_W-2:0], ge};
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.mul_x || i_cmd.mul_p) r_prod <= mul_a * mul_b;
        if (i_cmd.load_out) begin
            r_out_est  <= r_x;
            r_out_gain <= k_w;
        end
    end

    assign o_stat.div_last = (r_cnt == '0);
    assign o_est           = r_out_est;
    assign o_gain          = r_out_gain;

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mul_x |-> k_w <= ONE_Q16)
        else $error("gain above one");

    a_var_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd_p |=> r_p <= r_prior)
        else $error("posterior variance exceeds prior variance");

endmodule
